FILE: rtl/core/psfc_pkg.sv
// psfc_pkg: constants and shared types for the particle sensor frame checker
// no dependencies; used by every file in rtl/core
`timescale 1ns / 1ps

package psfc_pkg;

  localparam int FRAME_LEN  = 40;
  localparam int SUM_LEN    = 38;
  localparam int WORD_FIRST = 4;
  localparam int WORD_LAST  = 33;
  localparam int WORD_COUNT = 15;
  localparam int COUNT_MAX  = 63;
  localparam int BANK_COUNT = 2;
  localparam int MEM_DEPTH  = WORD_COUNT * BANK_COUNT;

  localparam int COUNT_W = 6;
  localparam int IDX_W   = 4;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } wr_req_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } emit_start_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  function automatic addr_t word_addr(logic bank, idx_t idx);
    addr_t base;
    base = bank ? addr_t'(WORD_COUNT) : '0;
    return base + addr_t'(idx);
  endfunction

endpackage

FILE: rtl/core/psfc_if.sv
// psfc_if: valid/ready channel interfaces for byte input and word output
// depends on psfc_pkg
`timescale 1ns / 1ps

interface psfc_in_if;
  logic          valid;
  logic          ready;
  psfc_pkg::byte_t rx_byte;
  logic          burst_end;

  modport source (output valid, output rx_byte, output burst_end, input ready);
  modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

interface psfc_out_if;
  logic            valid;
  logic            ready;
  psfc_pkg::idx_t  field_index;
  psfc_pkg::word_t field_value;
  logic            last_field;

  modport source (output valid, output field_index, output field_value,
                  output last_field, input ready);
  modport sink   (input valid, input field_index, input field_value,
                  input last_field, output ready);
endinterface

FILE: rtl/core/particle_sensor_frame_checker.sv
// particle_sensor_frame_checker: top level of the sensor frame checker
// depends on psfc_pkg, psfc_if, psfc_frame_acc, psfc_word_mem, psfc_emitter
//
//   channel   dir   payload                                    item
//   in_ch     in    rx_byte[7:0], burst_end                    one frame byte
//   out_ch    out   field_index[3:0], field_value[15:0],       one frame word
//                   last_field
//
// one byte is taken every cycle while in_ch.ready is high; the word store is
// a single memory with one write and one registered read port, words of the
// next frame go to the other bank; a checked frame gives fifteen words, read
// one per memory access into a two-entry output queue, a read being issued only
// while the queue has room for its word; each word passes the registered read
// port and a queue entry before it is valid; reset (rst_n low, synchronous)
// clears counters, sum and queue; no clearing pass; in_ch.ready drops only on
// byte 40 of a frame while the previous frame's words are still read from memory
`timescale 1ns / 1ps

module particle_sensor_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  psfc_in_if.sink     in_ch,
  psfc_out_if.source  out_ch
);

  psfc_pkg::count_t      count;
  psfc_pkg::wr_req_t     wr_req;
  psfc_pkg::rd_req_t     rd_req;
  psfc_pkg::word_t       rd_data;
  psfc_pkg::emit_start_t start;
  logic                  busy;
  logic                  accept;

  assign in_ch.ready = !(busy &&
                         (count == psfc_pkg::count_t'(psfc_pkg::FRAME_LEN - 1)));
  assign accept      = in_ch.valid && in_ch.ready;

  psfc_frame_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_ch.rx_byte),
    .burst_end (in_ch.burst_end),
    .count     (count),
    .wr_req    (wr_req),
    .start     (start)
  );

  psfc_word_mem u_mem (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  psfc_emitter u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/core/psfc_frame_acc.sv
// psfc_frame_acc: byte counter, checksum, word assembly and frame check
// depends on psfc_pkg; drives the word memory write port and the emitter start
`timescale 1ns / 1ps

module psfc_frame_acc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  psfc_pkg::byte_t       rx_byte,
  input  logic                  burst_end,
  output psfc_pkg::count_t      count,
  output psfc_pkg::wr_req_t     wr_req,
  output psfc_pkg::emit_start_t start
);

  psfc_pkg::count_t count_r, count_nxt;
  psfc_pkg::word_t  sum_r, sum_nxt;
  psfc_pkg::byte_t  chk_high_r, chk_high_nxt;
  psfc_pkg::byte_t  pend_high_r, pend_high_nxt;
  logic             wr_bank_r, wr_bank_nxt;
  psfc_pkg::count_t off;
  logic             in_words;
  logic             frame_ok;

  assign count    = count_r;
  assign off      = count_r - psfc_pkg::count_t'(psfc_pkg::WORD_FIRST);
  assign in_words = (count_r >= psfc_pkg::count_t'(psfc_pkg::WORD_FIRST)) &&
                    (count_r <= psfc_pkg::count_t'(psfc_pkg::WORD_LAST));
  assign frame_ok = burst_end &&
                    (count_r == psfc_pkg::count_t'(psfc_pkg::FRAME_LEN - 1)) &&
                    (chk_high_r == sum_r[15:8]) && (rx_byte == sum_r[7:0]);

  always_comb begin
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    chk_high_nxt  = chk_high_r;
    pend_high_nxt = pend_high_r;
    wr_bank_nxt   = wr_bank_r;
    wr_req.en     = 1'b0;
    wr_req.addr   = psfc_pkg::word_addr(wr_bank_r, psfc_pkg::idx_t'(off[4:1]));
    wr_req.data   = {pend_high_r, rx_byte};
    start.valid   = 1'b0;
    start.bank    = wr_bank_r;
    if (accept) begin
      if (count_r < psfc_pkg::count_t'(psfc_pkg::SUM_LEN)) begin
        sum_nxt = sum_r + psfc_pkg::word_t'(rx_byte);
      end
      if (in_words && !off[0]) begin
        pend_high_nxt = rx_byte;
      end
      if (in_words && off[0]) begin
        wr_req.en = 1'b1;
      end
      if (count_r == psfc_pkg::count_t'(psfc_pkg::SUM_LEN)) begin
        chk_high_nxt = rx_byte;
      end
      if (burst_end) begin
        count_nxt = '0;
        sum_nxt   = '0;
        if (frame_ok) begin
          start.valid = 1'b1;
          wr_bank_nxt = !wr_bank_r;
        end
      end else if (count_r < psfc_pkg::count_t'(psfc_pkg::COUNT_MAX)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      chk_high_r  <= '0;
      pend_high_r <= '0;
      wr_bank_r   <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      chk_high_r  <= chk_high_nxt;
      pend_high_r <= pend_high_nxt;
      wr_bank_r   <= wr_bank_nxt;
    end
  end

endmodule

FILE: rtl/core/psfc_word_mem.sv
// psfc_word_mem: two banks of fifteen assembled words, one write and one read port
// depends on psfc_pkg; read data is registered
`timescale 1ns / 1ps

module psfc_word_mem (
  input  logic              clk,
  input  psfc_pkg::wr_req_t wr_req,
  input  psfc_pkg::rd_req_t rd_req,
  output psfc_pkg::word_t   rd_data
);

  psfc_pkg::word_t mem [psfc_pkg::MEM_DEPTH];
  psfc_pkg::word_t rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

endmodule

FILE: rtl/core/psfc_emitter.sv
// psfc_emitter: reads the fifteen words of a checked frame and queues them out
// depends on psfc_pkg and psfc_if; reads psfc_word_mem through rd_req
`timescale 1ns / 1ps

module psfc_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psfc_pkg::emit_start_t start,
  output logic                  busy,
  output psfc_pkg::rd_req_t     rd_req,
  input  psfc_pkg::word_t       rd_data,
  psfc_out_if.source            out_ch
);

  logic           busy_r, busy_nxt;
  logic           bank_r, bank_nxt;
  psfc_pkg::idx_t idx_r, idx_nxt;
  logic           inflight_r;
  psfc_pkg::idx_t rd_idx_r;
  logic [1:0]     occ_r, occ_nxt;
  logic           wr_ptr_r, rd_ptr_r;
  psfc_pkg::idx_t q_idx [2];
  psfc_pkg::word_t q_val [2];
  logic           issue;
  logic           pop;
  logic           last_idx;

  assign last_idx    = (idx_r == psfc_pkg::idx_t'(psfc_pkg::WORD_COUNT - 1));
  assign issue       = busy_r && ({1'b0, inflight_r} + occ_r < 2'd2);
  assign pop         = out_ch.valid && out_ch.ready;
  assign busy        = busy_r;
  assign rd_req.en   = issue;
  assign rd_req.addr = psfc_pkg::word_addr(bank_r, idx_r);

  assign out_ch.valid       = (occ_r != 2'd0);
  assign out_ch.field_index = q_idx[rd_ptr_r];
  assign out_ch.field_value = q_val[rd_ptr_r];
  assign out_ch.last_field  =
    (q_idx[rd_ptr_r] == psfc_pkg::idx_t'(psfc_pkg::WORD_COUNT - 1));

  always_comb begin
    busy_nxt = busy_r;
    bank_nxt = bank_r;
    idx_nxt  = idx_r;
    if (start.valid && !busy_r) begin
      busy_nxt = 1'b1;
      bank_nxt = start.bank;
      idx_nxt  = '0;
    end else if (issue) begin
      idx_nxt = idx_r + 1'b1;
      if (last_idx) begin
        busy_nxt = 1'b0;
      end
    end
    occ_nxt = occ_r + {1'b0, inflight_r} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      bank_r     <= 1'b0;
      idx_r      <= '0;
      inflight_r <= 1'b0;
      occ_r      <= '0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      bank_r     <= bank_nxt;
      idx_r      <= idx_nxt;
      inflight_r <= issue;
      occ_r      <= occ_nxt;
      if (inflight_r) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r <= idx_r;
    end
    if (inflight_r) begin
      q_idx[wr_ptr_r] <= rd_idx_r;
      q_val[wr_ptr_r] <= rd_data;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 2'd2)
    else $error("output queue overflow");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start.valid |-> !busy_r)
    else $error("frame start while previous frame still reading");

  a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
    issue && last_idx |=> !busy_r)
    else $error("reader did not stop after the last word");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r |-> occ_r < 2'd2 || pop)
    else $error("read data returned with no queue slot");

endmodule

FILE: bench/particle_sensor_frame_checker_test.sv
// particle_sensor_frame_checker_test: self-checking bench for the sensor frame checker
// feeds byte bursts, predicts the emitted words and checks them in order
// depends on psfc_pkg, psfc_if and the rtl/core sources
`timescale 1ns / 1ps

module particle_sensor_frame_checker_test;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_t;
  typedef enum int {KIND_GOOD, KIND_BAD_HIGH, KIND_BAD_LOW, KIND_NOISE} burst_kind_t;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct {
    psfc_pkg::byte_t data;
    logic            last;
    logic            hold;
    phase_t          phase;
  } rx_item_t;

  typedef struct packed {
    psfc_pkg::idx_t  index;
    psfc_pkg::word_t value;
    logic            last;
  } field_item_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 64;

  int send_idle [4] = '{0, 54, 0, 26};
  int recv_stall [4] = '{0, 0, 54, 26};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psfc_in_if  in_ch ();
  psfc_out_if out_ch ();

  particle_sensor_frame_checker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rx_item_t    rx_byte_q [$];
  field_item_t word_q [$];
  phase_t      phase_now = PH_FREE;

  psfc_pkg::count_t byte_count;
  psfc_pkg::word_t  running_sum;
  psfc_pkg::byte_t  checksum_high;
  psfc_pkg::byte_t  pending_high;
  psfc_pkg::word_t  word_store [psfc_pkg::WORD_COUNT];

  int bytes_sent;
  int bursts_built;
  int frames_passed;
  int words_checked;
  int errors;
  int idle_cycles;

  function automatic void predict_frame_byte(psfc_pkg::byte_t b, logic e);
    int pos;
    int off;
    pos = int'(byte_count);
    if (pos < psfc_pkg::SUM_LEN) running_sum = running_sum + psfc_pkg::word_t'(b);
    if (pos >= psfc_pkg::WORD_FIRST && pos <= psfc_pkg::WORD_LAST) begin
      off = pos - psfc_pkg::WORD_FIRST;
      if (off % 2 == 0) pending_high = b;
      else word_store[off / 2] = {pending_high, b};
    end
    if (pos == psfc_pkg::SUM_LEN) checksum_high = b;
    if (e) begin
      if (pos == psfc_pkg::FRAME_LEN - 1 && checksum_high == running_sum[15:8] &&
          b == running_sum[7:0]) begin
        for (int k = 0; k < psfc_pkg::WORD_COUNT; k++)
          word_q.push_back('{psfc_pkg::idx_t'(k), word_store[k],
                             k == psfc_pkg::WORD_COUNT - 1});
        frames_passed++;
      end
      byte_count = '0;
      running_sum = '0;
    end else if (byte_count < psfc_pkg::COUNT_MAX) begin
      byte_count = byte_count + 1'b1;
    end
  endfunction

  function automatic psfc_pkg::byte_t pick_byte(fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return psfc_pkg::byte_t'($urandom_range(255));
    endcase
  endfunction

  // bytes 38 and 39 carry the checksum unless the burst is noise
  function automatic void push_burst(phase_t ph, int len, burst_kind_t kind, fill_t fill,
                                     logic hold);
    psfc_pkg::word_t sum;
    psfc_pkg::byte_t b;
    sum = '0;
    for (int i = 0; i < len; i++) begin
      if (kind != KIND_NOISE && i == psfc_pkg::SUM_LEN) begin
        b = sum[15:8];
        if (kind == KIND_BAD_HIGH) b = b ^ psfc_pkg::byte_t'($urandom_range(255, 1));
      end else if (kind != KIND_NOISE && i == psfc_pkg::SUM_LEN + 1) begin
        b = sum[7:0];
        if (kind == KIND_BAD_LOW) b = b ^ psfc_pkg::byte_t'($urandom_range(255, 1));
      end else begin
        b = pick_byte(fill);
      end
      if (i < psfc_pkg::SUM_LEN) sum = sum + psfc_pkg::word_t'(b);
      rx_byte_q.push_back('{b, i == len - 1, hold && i == 0, ph});
    end
    bursts_built++;
  endfunction

  always @(posedge clk) begin : drive
    logic     busy;
    logic     launch;
    rx_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      busy = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_frame_byte(in_ch.rx_byte, in_ch.burst_end);
        bytes_sent++;
      end
      if (!busy) begin
        launch = 1'b0;
        if (rx_byte_q.size() != 0) begin
          nxt = rx_byte_q[0];
          if (!(nxt.hold && word_q.size() != 0) &&
              $urandom_range(99) >= send_idle[nxt.phase])
            launch = 1'b1;
        end
        if (launch) begin
          void'(rx_byte_q.pop_front());
          in_ch.valid     <= 1'b1;
          in_ch.rx_byte   <= nxt.data;
          in_ch.burst_end <= nxt.last;
          phase_now       <= nxt.phase;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    field_item_t got;
    field_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.field_index, out_ch.field_value, out_ch.last_field};
        if (word_q.size() == 0) begin
          $display("%0t unexpected word: expected none, got index %0d value %h last %b",
                   $time, got.index, got.value, got.last);
          errors++;
        end else begin
          want = word_q.pop_front();
          words_checked++;
          if (got !== want) begin
            $display({"%0t word mismatch: expected index %0d value %h last %b, ",
                      "got index %0d value %h last %b"},
                     $time, want.index, want.value, want.last,
                     got.index, got.value, got.last);
            errors++;
          end
        end
      end
      out_ch.ready <= $urandom_range(99) >= recv_stall[phase_now];
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t timeout: %0d bytes still queued, %0d words expected",
               $time, rx_byte_q.size(), word_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    burst_kind_t bad_kind;

    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.burst_end = 1'b0;
    out_ch.ready = 1'b0;
    byte_count = '0;
    running_sum = '0;
    checksum_high = '0;
    pending_high = '0;
    foreach (word_store[i]) word_store[i] = '0;
    bytes_sent = 0;
    bursts_built = 0;
    frames_passed = 0;
    words_checked = 0;
    errors = 0;
    idle_cycles = 0;

    // a one-byte noise burst, then one burst per idle pattern; the last one waits for every pending word
    bad_kind = $urandom_range(1) ? KIND_BAD_HIGH : KIND_BAD_LOW;
    push_burst(PH_FREE, 1, KIND_NOISE, FILL_RANDOM, 1'b0);
    push_burst(PH_FREE, psfc_pkg::FRAME_LEN, KIND_GOOD, FILL_ONES, 1'b0);
    push_burst(PH_SEND_IDLE, psfc_pkg::FRAME_LEN, bad_kind, FILL_RANDOM, 1'b0);
    push_burst(PH_RECV_STALL, psfc_pkg::FRAME_LEN, KIND_GOOD, FILL_RANDOM, 1'b0);
    push_burst(PH_BOTH, psfc_pkg::FRAME_LEN, KIND_GOOD, FILL_RANDOM, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_byte_q.size() != 0 || in_ch.valid || word_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d bursts; %0d frames passed the checksum",
             bytes_sent, bursts_built, frames_passed);
    $display("%0d words checked over good, bad-checksum and one-byte bursts, four idle patterns",
             words_checked);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/psfc_pkg.sv
rtl/core/psfc_if.sv
rtl/core/psfc_frame_acc.sv
rtl/core/psfc_word_mem.sv
rtl/core/psfc_emitter.sv
rtl/core/particle_sensor_frame_checker.sv
bench/particle_sensor_frame_checker_test.sv
